[hdl/lz77_longest_match_finder_core_assert.svh]
// assertion macros for the longest match finder
// each takes a label, the clock, the active-low reset, a condition and a consequence
`ifndef LZ77_LONGEST_MATCH_FINDER_CORE_ASSERT_SVH
`define LZ77_LONGEST_MATCH_FINDER_CORE_ASSERT_SVH

// consequence must hold in the same cycle
`define LMF_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("lz77 match finder: same-cycle check failed");

// consequence must hold in the following cycle
`define LMF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("lz77 match finder: next-cycle check failed");

`endif

[hdl/lz77lmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77lmf_pkg
// shared types and constants of the lz77 longest match finder
// ----------------------------------------------------------------------------
package lz77lmf_pkg;

  localparam int DICT_DEPTH_DEF = 1024;
  localparam int LOOK_DEPTH_DEF = 32;

  localparam int CFG_DICT_W   = 11;
  localparam int CFG_LOOK_W   = 6;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_DICT_W-1:0] DICT_SIZE_RST = 11'd1024;
  localparam logic [CFG_LOOK_W-1:0] LOOK_SIZE_RST = 6'd16;

  // register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DICT_SIZE = 1'b0,
    REG_LOOK_SIZE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [9:0] match_offset;
    logic [5:0] match_length;
    logic [7:0] next_symbol;
    logic       symbol_valid;
  } out_item_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wr_data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_CMP,
    ST_FETCH,
    ST_DONE
  } state_t;

endpackage

[hdl/lz77lmf_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77lmf_chan_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface lz77lmf_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[hdl/lz77lmf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77lmf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lz77lmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/lz77_longest_match_finder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_longest_match_finder_core
// brute-force lz77 longest match search over one loaded window
// ----------------------------------------------------------------------------
// Bytes of a window are taken one per cycle; the first dict_size bytes go to the
// dictionary ram and the rest to the lookahead ram. The window closes on a byte
// flagged last or when dict_size+look_size bytes are in. The block then walks
// every dictionary position with one shared byte comparator, reading both rams
// through their single read ports: each compared byte takes a read state and then
// a compare state, a position stops at its first mismatch, and the walk stops
// early once no later position can beat the best length. The block then fetches
// the following symbol and registers the result. The input is not ready during the
// search. The result sits in an output register, so the next window can load
// while it waits to be taken. Configuration is latched at the first byte of a
// window; out-of-range sizes are clamped to 1..depth. No clearing pass is needed.
module lz77_longest_match_finder_core
  import lz77lmf_pkg::*;
#(
  parameter int DICT_DEPTH = DICT_DEPTH_DEF,
  parameter int LOOK_DEPTH = LOOK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lz77lmf_chan_if.sink   in_if,
  lz77lmf_chan_if.source out_if,
  lz77lmf_chan_if.sink   cfg_if
);

  `include "lz77_longest_match_finder_core_assert.svh"

  // widths
  localparam int DA  = $clog2(DICT_DEPTH);
  localparam int DW  = $clog2(DICT_DEPTH + 1);
  localparam int LA  = $clog2(LOOK_DEPTH);
  localparam int LW  = $clog2(LOOK_DEPTH + 1);
  localparam int FW  = $clog2(DICT_DEPTH + LOOK_DEPTH + 1);
  localparam int DCW = (DW > CFG_DICT_W) ? DW : CFG_DICT_W;
  localparam int LCW = (LW > CFG_LOOK_W) ? LW : CFG_LOOK_W;
  localparam int SW  = ((DW > LW) ? DW : LW) + 1;

  // configuration registers
  logic [CFG_DICT_W-1:0] dict_size_r;
  logic [CFG_LOOK_W-1:0] look_size_r;

  // control and datapath registers
  state_t          state_r, state_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [DW-1:0]   win_dict_r, win_dict_nxt;
  logic [LW-1:0]   win_look_r, win_look_nxt;
  logic [LW-1:0]   avail_r, avail_nxt;
  logic [LW-1:0]   best_len_r, best_len_nxt;
  logic [DA-1:0]   best_off_r, best_off_nxt;
  logic [DA-1:0]   pos_r, pos_nxt;
  logic [LA-1:0]   k_r, k_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // ram ports
  logic          dict_we, look_we;
  logic [DA-1:0] dict_waddr, dict_raddr;
  logic [LA-1:0] look_waddr, look_raddr;
  logic [7:0]    dict_rdata, look_rdata;

  // load-side helpers
  logic [DCW-1:0] dict_cfg_ext;
  logic [LCW-1:0] look_cfg_ext;
  logic [DW-1:0]  clamp_dict, eff_dict;
  logic [LW-1:0]  clamp_look, eff_look;
  logic [FW-1:0]  look_idx, fill_inc;
  logic           in_dict, in_look, win_close, in_xfer;

  // search-side helpers
  logic [SW-1:0]  lim, room;
  logic [LW-1:0]  run_len, best_new;
  logic [DA-1:0]  off_new;
  logic           byte_eq, run_more, scan_done, capture;

  assign in_if.ready  = (state_r == ST_LOAD);
  assign cfg_if.ready = 1'b1;
  assign in_xfer      = in_if.valid && in_if.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_size_r <= DICT_SIZE_RST;
      look_size_r <= LOOK_SIZE_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.payload.reg_index))
        REG_DICT_SIZE: dict_size_r <= cfg_if.payload.wr_data[CFG_DICT_W-1:0];
        REG_LOOK_SIZE: look_size_r <= cfg_if.payload.wr_data[CFG_LOOK_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to 1..depth
  always_comb begin
    dict_cfg_ext = DCW'(dict_size_r);
    look_cfg_ext = LCW'(look_size_r);
    if (dict_cfg_ext == '0) begin
      clamp_dict = DW'(1);
    end else if (dict_cfg_ext > DCW'(DICT_DEPTH)) begin
      clamp_dict = DW'(DICT_DEPTH);
    end else begin
      clamp_dict = DW'(dict_cfg_ext);
    end
    if (look_cfg_ext == '0) begin
      clamp_look = LW'(1);
    end else if (look_cfg_ext > LCW'(LOOK_DEPTH)) begin
      clamp_look = LW'(LOOK_DEPTH);
    end else begin
      clamp_look = LW'(look_cfg_ext);
    end
  end

  // window sizes are latched on the first byte
  assign eff_dict  = (fill_r == '0) ? clamp_dict : win_dict_r;
  assign eff_look  = (fill_r == '0) ? clamp_look : win_look_r;
  assign in_dict   = fill_r < FW'(eff_dict);
  assign look_idx  = fill_r - FW'(eff_dict);
  assign in_look   = !in_dict && (look_idx < FW'(eff_look));
  assign fill_inc  = fill_r + FW'(1);
  assign win_close = in_if.payload.last || (fill_inc >= FW'(eff_dict) + FW'(eff_look));

  // ram write side
  assign dict_we    = in_xfer && in_dict;
  assign dict_waddr = fill_r[DA-1:0];
  assign look_we    = in_xfer && in_look;
  assign look_waddr = look_idx[LA-1:0];

  // ram read side: scan addresses, then the symbol after the match
  assign dict_raddr = DA'(SW'(pos_r) + SW'(k_r));
  assign look_raddr = (state_r == ST_FETCH || state_r == ST_DONE) ?
                      LA'(best_len_r) : k_r;

  lz77lmf_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_dict_ram (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (in_if.payload.data_byte),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  lz77lmf_ram #(.WIDTH(8), .DEPTH(LOOK_DEPTH)) u_look_ram (
    .clk   (clk),
    .we    (look_we),
    .waddr (look_waddr),
    .wdata (in_if.payload.data_byte),
    .raddr (look_raddr),
    .rdata (look_rdata)
  );

  // shared comparator and run bookkeeping
  always_comb begin
    room     = SW'(win_dict_r) - SW'(pos_r);
    lim      = (room < SW'(avail_r)) ? room : SW'(avail_r);
    byte_eq  = (dict_rdata == look_rdata);
    run_len  = byte_eq ? LW'(SW'(k_r) + SW'(1)) : LW'(k_r);
    run_more = byte_eq && ((SW'(k_r) + SW'(1)) < lim);
    // strictly longer only, so the earliest position wins a tie
    if (run_len > best_len_r) begin
      best_new = run_len;
      off_new  = pos_r;
    end else begin
      best_new = best_len_r;
      off_new  = best_off_r;
    end
    // stop once no later position has room to beat the best
    scan_done = ((SW'(pos_r) + SW'(1) + SW'(best_new)) >= SW'(win_dict_r)) ||
                (best_new >= avail_r);
  end

  assign capture = (state_r == ST_DONE) && (!out_valid_r || out_if.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && win_close) begin
          state_nxt = (fill_inc > FW'(eff_dict)) ? ST_RD : ST_FETCH;
        end
      end
      ST_RD:    state_nxt = ST_CMP;
      ST_CMP: begin
        if (run_more || !scan_done) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_DONE;
      ST_DONE: begin
        if (capture) begin
          state_nxt = ST_LOAD;
        end
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // datapath next values
  always_comb begin
    fill_nxt      = fill_r;
    win_dict_nxt  = win_dict_r;
    win_look_nxt  = win_look_r;
    avail_nxt     = avail_r;
    best_len_nxt  = best_len_r;
    best_off_nxt  = best_off_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          win_dict_nxt = eff_dict;
          win_look_nxt = eff_look;
          fill_nxt     = win_close ? '0 : fill_inc;
          if (win_close) begin
            // lookahead bytes actually loaded, never above the latched size
            avail_nxt    = (fill_inc > FW'(eff_dict)) ? LW'(fill_inc - FW'(eff_dict)) : '0;
            best_len_nxt = '0;
            best_off_nxt = '0;
            pos_nxt      = '0;
            k_nxt        = '0;
          end
        end
      end
      ST_RD: ;
      ST_CMP: begin
        if (run_more) begin
          k_nxt = k_r + LA'(1);
        end else begin
          best_len_nxt = best_new;
          best_off_nxt = off_new;
          pos_nxt      = pos_r + DA'(1);
          k_nxt        = '0;
        end
      end
      ST_FETCH: ;
      ST_DONE: begin
        if (capture) begin
          out_valid_nxt        = 1'b1;
          out_nxt.match_offset = 10'(best_off_r);
          out_nxt.match_length = 6'(best_len_r);
          out_nxt.symbol_valid = (best_len_r < avail_r);
          out_nxt.next_symbol  = (best_len_r < avail_r) ? look_rdata : 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    win_dict_r <= win_dict_nxt;
    win_look_r <= win_look_nxt;
    avail_r    <= avail_nxt;
    best_len_r <= best_len_nxt;
    best_off_r <= best_off_nxt;
    pos_r      <= pos_nxt;
    k_r        <= k_nxt;
    out_r      <= out_nxt;
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

  // compared lookahead byte always lies within the loaded lookahead
  `LMF_ASSERT_SAME(a_cmp_in_range, clk, rst_n, state_r == ST_CMP, LW'(k_r) < avail_r)
  // best length never exceeds the loaded lookahead while searching
  `LMF_ASSERT_SAME(a_best_bounded, clk, rst_n, state_r == ST_CMP || state_r == ST_FETCH ||
                   state_r == ST_DONE, best_len_r <= avail_r)
  // a held result is never overwritten by the next one
  `LMF_ASSERT_NEXT(a_no_overwrite, clk, rst_n, state_r == ST_DONE && out_valid_r &&
                   !out_if.ready, state_r == ST_DONE && $stable(out_r))
  // a zero-length match reports offset zero
  `LMF_ASSERT_SAME(a_nomatch_off, clk, rst_n, out_valid_r && out_r.match_length == 6'd0,
                   out_r.match_offset == 10'd0)

endmodule

[bench/lz77_longest_match_finder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_longest_match_finder_core_tb
// self-checking bench for the brute-force lz77 longest match finder: windows
// of bytes are streamed in under random idling and back-pressure, a behavioural
// search predicts each result and every output transfer is compared with it
// ----------------------------------------------------------------------------
module lz77_longest_match_finder_core_tb;
  import lz77lmf_pkg::*;

  localparam int DICT_DEPTH    = DICT_DEPTH_DEF;
  localparam int LOOK_DEPTH    = LOOK_DEPTH_DEF;
  // watchdog bound on the length of the whole run, well above the slowest legal run
  localparam int CYCLE_LIMIT   = 4000000;
  // margin after the last result for the result fetch and output register
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BYTES  = 450;

  // how a generated window is closed
  typedef enum int {
    WIN_NO_LOOKAHEAD,  // last lands inside the dictionary part
    WIN_OPEN_END,      // last lands somewhere in the lookahead
    WIN_FULL           // closes on size, last flag random
  } window_kind_t;

  logic clk;
  logic rst_n;

  lz77lmf_chan_if #(.payload_t(in_item_t))  in_if  ();
  lz77lmf_chan_if #(.payload_t(out_item_t)) out_if ();
  lz77lmf_chan_if #(.payload_t(cfg_wr_t))   cfg_if ();

  lz77_longest_match_finder_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // --------------------------------------------------------------------------
  // behavioural copy of the match finder
  // --------------------------------------------------------------------------
  logic [7:0]            dict_mem [DICT_DEPTH];
  logic [7:0]            look_mem [LOOK_DEPTH];
  int                    win_fill     = 0;
  int                    win_dict_len = 0;
  int                    win_look_len = 0;
  logic [CFG_DICT_W-1:0] dict_size_reg = DICT_SIZE_RST;
  logic [CFG_LOOK_W-1:0] look_size_reg = LOOK_SIZE_RST;

  out_item_t expected_matches [$];

  int  fail_count  = 0;
  int  bytes_sent  = 0;
  int  cycle_count = 0;
  bit  feed_idle_en = 1'b1;
  bit  sink_idle_en = 1'b1;
  int  sink_hold_cycles = 0;

  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // store one accepted byte; on window close run the brute-force search
  function automatic void take_window_byte(in_item_t item);
    int        avail;
    int        best_off;
    int        best_len;
    int        len;
    int        pos;
    int        k;
    bit        hit;
    out_item_t res;
    // window sizes are latched at the first byte only
    if (win_fill == 0) begin
      win_dict_len = clamp_size(int'(dict_size_reg), DICT_DEPTH);
      win_look_len = clamp_size(int'(look_size_reg), LOOK_DEPTH);
    end
    if (win_fill < win_dict_len) begin
      dict_mem[win_fill] = item.data_byte;
    end else if (win_fill - win_dict_len < win_look_len) begin
      look_mem[win_fill - win_dict_len] = item.data_byte;
    end
    win_fill++;
    if (!item.last && win_fill < win_dict_len + win_look_len) return;

    avail = (win_fill > win_dict_len) ? win_fill - win_dict_len : 0;
    if (avail > win_look_len) avail = win_look_len;
    best_off = 0;
    best_len = 0;
    // longest first, earliest position wins, match must sit inside the dictionary
    len = avail;
    while (len >= 1 && best_len == 0) begin
      if (len <= win_dict_len) begin
        pos = 0;
        while (best_len == 0 && pos + len <= win_dict_len) begin
          hit = 1'b1;
          for (k = 0; k < len && hit; k++) begin
            if (dict_mem[pos + k] != look_mem[k]) hit = 1'b0;
          end
          if (hit) begin
            best_off = pos;
            best_len = len;
          end
          pos++;
        end
      end
      len--;
    end

    res.match_offset = best_off[9:0];
    res.match_length = best_len[5:0];
    res.symbol_valid = (best_len < avail);
    res.next_symbol  = (best_len < avail) ? look_mem[best_len] : 8'h00;
    expected_matches.insert(expected_matches.size(), res);
    win_fill = 0;
  endfunction

  // --------------------------------------------------------------------------
  // clock, watchdog and monitors
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[lz77_longest_match_finder_core] ERROR");
    $finish;
  end

  // register writes update the predicted configuration
  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.payload.reg_index == REG_DICT_SIZE) begin
        dict_size_reg = cfg_if.payload.wr_data;
      end else if (cfg_if.payload.reg_index == REG_LOOK_SIZE) begin
        look_size_reg = cfg_if.payload.wr_data[CFG_LOOK_W-1:0];
      end
    end
  end

  // every accepted input byte goes through the predictor
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) take_window_byte(in_if.payload);
  end

  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // each output transfer is compared with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_matches.size() == 0) begin
        $display("%0t: result with nothing expected, offset %0d length %0d symbol %0d valid %0d",
                 $time, got.match_offset, got.match_length, got.next_symbol,
                 got.symbol_valid);
        fail_count++;
      end else begin
        want = expected_matches.pop_front();
        check_field("match_offset", 32'(want.match_offset), 32'(got.match_offset));
        check_field("match_length", 32'(want.match_length), 32'(got.match_length));
        check_field("next_symbol",  32'(want.next_symbol),  32'(got.next_symbol));
        check_field("symbol_valid", 32'(want.symbol_valid), 32'(got.symbol_valid));
      end
    end
  end

  // --------------------------------------------------------------------------
  // result sink: random gaps, plus an occasional long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    int hold;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        hold = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = sink_idle_en ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      // leave early as well when a hold-off is requested
      do @(posedge clk);
      while (!(out_if.valid && out_if.ready) && sink_hold_cycles == 0);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers, all called right after a rising edge
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] value, logic is_last);
    int gap;
    gap = feed_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{data_byte: value, last: is_last};
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    bytes_sent++;
  endtask

  // drop valid after the last transfer so it is not taken twice
  task automatic release_input();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only ever called with the block idle
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{reg_index: idx, wr_data: value};
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(logic [CFG_DATA_W-1:0] dict_v, logic [CFG_DATA_W-1:0] look_v);
    release_input();
    wait_results_drained();
    write_reg(REG_DICT_SIZE, dict_v);
    write_reg(REG_LOOK_SIZE, look_v);
  endtask

  task automatic send_sequence(input logic [7:0] seq [$], input bit mark_last);
    int i;
    for (i = 0; i < seq.size(); i++) begin
      send_byte(seq[i], mark_last && (i == seq.size() - 1));
    end
  endtask

  // one well-formed window; lookahead is often seeded from the dictionary so
  // that long matches actually turn up
  task automatic send_window(window_kind_t kind);
    logic [7:0] seq [$];
    int         wd;
    int         wl;
    int         n;
    int         i;
    int         src;
    int         cp_len;
    int         alpha_hi;
    bit         mark_last;
    wd = clamp_size(int'(dict_size_reg), DICT_DEPTH);
    wl = clamp_size(int'(look_size_reg), LOOK_DEPTH);
    unique case (kind)
      WIN_NO_LOOKAHEAD: begin
        n = $urandom_range(1, wd);
        mark_last = 1'b1;
      end
      WIN_OPEN_END: begin
        n = wd + $urandom_range(1, wl);
        mark_last = 1'b1;
      end
      default: begin
        n = wd + wl;
        mark_last = 1'($urandom_range(0, 1));
      end
    endcase
    // tiny alphabets give many partial matches; keep big dictionaries full-range
    alpha_hi = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(1, 3);
    if (wd > 64) alpha_hi = 255;
    for (i = 0; i < n; i++) seq.insert(seq.size(), 8'($urandom_range(0, alpha_hi)));
    if (n > wd && $urandom_range(0, 1) == 1) begin
      src    = $urandom_range(0, wd - 1);
      cp_len = $urandom_range(1, n - wd);
      for (i = 0; i < cp_len && src + i < wd; i++) seq[wd + i] = seq[src + i];
    end
    send_sequence(seq, mark_last);
  endtask

  function automatic window_kind_t pick_window_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return WIN_NO_LOOKAHEAD;
    if (r < 50) return WIN_OPEN_END;
    return WIN_FULL;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // one full window at the reset sizes, no register written yet; this is
  // also the largest dictionary
  task automatic test_reset_window();
    send_window(WIN_FULL);
  endtask

  task automatic test_directed_cases();
    logic [7:0] seq [$];
    reconfigure(11'd3, 11'd3);
    // window ends exactly on the dictionary, nothing to search
    seq = '{8'h11, 8'h22, 8'h33};
    send_sequence(seq, 1'b1);
    // no lookahead byte in the dictionary
    seq = '{8'h00, 8'h00, 8'h00, 8'hFF};
    send_sequence(seq, 1'b1);
    // whole lookahead matched, no following symbol
    seq = '{8'h12, 8'h34, 8'h56, 8'h34, 8'h56};
    send_sequence(seq, 1'b1);
    // the match at the start beats a shorter one at the end of the dictionary; closes on size
    seq = '{8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hFF};
    send_sequence(seq, 1'b0);
    // single-byte match at the end of the dictionary
    seq = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h80};
    send_sequence(seq, 1'b1);
    // smallest window possible
    reconfigure(11'd1, 11'd1);
    seq = '{8'h7F, 8'h7F};
    send_sequence(seq, 1'b0);
  endtask

  // clamping of zero sizes and of oversized lookahead values
  task automatic test_size_extremes();
    reconfigure(11'd0, 11'd0);
    repeat (4) send_window(pick_window_kind());
    // upper data bits of the lookahead register are dropped, 35 clamps to 32
    reconfigure(11'd1, 11'h7E3);
    repeat (3) send_window(pick_window_kind());
    reconfigure(11'd40, 11'd63);
    repeat (3) send_window(WIN_FULL);
  endtask

  task automatic test_random_windows();
    int start;
    int phase_end;
    logic [CFG_DATA_W-1:0] dict_v;
    logic [CFG_DATA_W-1:0] look_v;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      dict_v = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 40));
      look_v = 11'($urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0) look_v[10:6] = 5'($urandom_range(0, 31));
      reconfigure(dict_v, look_v);
      // some phases run flat out on one side or both
      feed_idle_en = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      phase_end = bytes_sent + $urandom_range(60, 160);
      while (bytes_sent < phase_end) begin
        send_window(pick_window_kind());
        if ($urandom_range(0, 15) == 0) begin
          release_input();
          while (expected_matches.size() != 0) @(posedge clk);
        end
      end
    end
    feed_idle_en = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // sink holds off while tiny windows keep coming, so the result register
  // fills and the input stalls; then the sender waits for a full drain
  task automatic test_backpressure();
    reconfigure(11'd2, 11'd2);
    feed_idle_en = 1'b0;
    sink_hold_cycles = 600;
    repeat (40) send_window(WIN_FULL);
    release_input();
    while (expected_matches.size() != 0) @(posedge clk);
    feed_idle_en = 1'b1;
    repeat (10) send_window(pick_window_kind());
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_directed_cases();
    test_size_extremes();
    test_random_windows();
    test_backpressure();

    release_input();
    wait_results_drained();
    if (fail_count == 0) begin
      $display("[lz77_longest_match_finder_core] OK");
    end else begin
      $display("[lz77_longest_match_finder_core] ERROR");
    end
    $finish;
  end

endmodule

[lz77_longest_match_finder_core.f]
+incdir+hdl
hdl/lz77lmf_pkg.sv
hdl/lz77lmf_chan_if.sv
hdl/lz77lmf_ram.sv
hdl/lz77_longest_match_finder_core.sv
bench/lz77_longest_match_finder_core_tb.sv
